// ===== hdl/nlsc_pkg.sv =====
// nlsc_pkg: shared types and constants of the length-prefix to start-code framer
// used by every module of the block; no dependencies
`default_nettype none

package nlsc_pkg;

    // register indexes on the configuration port
    localparam logic [1:0] REG_LEN_BYTES = 2'd0;
    localparam logic [1:0] REG_CODEC     = 2'd1;
    localparam logic [1:0] REG_START3    = 2'd2;

    localparam logic [1:0] CODEC_H264 = 2'd0;
    localparam logic [1:0] CODEC_H265 = 2'd1;
    localparam logic [1:0] CODEC_H266 = 2'd2;

    localparam logic [2:0] LEN_BYTES_MIN   = 3'd2;
    localparam logic [2:0] LEN_BYTES_MAX   = 3'd4;
    localparam logic [2:0] LEN_BYTES_RESET = 3'd4;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 64;

    typedef enum logic [1:0] {
        PH_LEN,
        PH_FIRST,
        PH_HOLD,
        PH_BODY
    } t_phase;

    typedef struct packed {
        logic [2:0]  len_bytes;
        logic [1:0]  codec;
        logic [63:0] start3_mask;
    } t_cfg;

    // one output run: optional start code, then up to two data bytes
    typedef struct packed {
        logic       has_start;
        logic       start3;
        logic [1:0] ndata;
        logic [7:0] d0;
        logic [7:0] d1;
        logic       last;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic not_empty;
    } t_q_status;

endpackage

`default_nettype wire

// ===== hdl/nlsc_if.sv =====
// nlsc_in_if / nlsc_out_if: valid-ready byte channels of the framer
// plain signals only; no dependencies
`default_nettype none

interface nlsc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_in_packet;

    modport source (output valid, output data_byte, output last_in_packet, input ready);
    modport sink   (input valid, input data_byte, input last_in_packet, output ready);
endinterface

interface nlsc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       packet_end;

    modport source (output valid, output out_byte, output last_of_run, output packet_end,
                    input ready);
    modport sink   (input valid, input out_byte, input last_of_run, input packet_end,
                    output ready);
endinterface

`default_nettype wire

// ===== hdl/nlsc_front.sv =====
// nlsc_front: parses length fields, finds the nal type and turns each input item
// into at most one run command for the queue; uses nlsc_pkg and nlsc_in_if
`default_nettype none

module nlsc_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    nlsc_in_if.sink             i_in,
    input  nlsc_pkg::t_cfg      i_cfg,
    input  nlsc_pkg::t_q_status i_q,
    output logic                o_push,
    output nlsc_pkg::t_cmd      o_cmd
);

    nlsc_pkg::t_phase r_phase, n_phase;
    logic [2:0]       r_seen, n_seen;
    logic [31:0]      r_accum, n_accum;
    logic [31:0]      r_left, n_left;
    logic [7:0]       r_held, n_held;

    logic             accept;
    logic             emit;
    logic [2:0]       eff_len;
    logic [31:0]      left_dec;
    logic [5:0]       nal_type;
    logic [7:0]       b;
    logic             last;

    assign b          = i_in.data_byte;
    assign last       = i_in.last_in_packet;
    assign i_in.ready = !i_q.full;
    assign accept     = i_in.valid && !i_q.full;
    assign o_push     = accept && emit;
    assign left_dec   = r_left - 32'd1;

    always_comb begin
        if (i_cfg.len_bytes < nlsc_pkg::LEN_BYTES_MIN) begin
            eff_len = nlsc_pkg::LEN_BYTES_MIN;
        end else if (i_cfg.len_bytes > nlsc_pkg::LEN_BYTES_MAX) begin
            eff_len = nlsc_pkg::LEN_BYTES_MAX;
        end else begin
            eff_len = i_cfg.len_bytes;
        end
    end

    always_comb begin
        if (r_phase == nlsc_pkg::PH_HOLD) begin
            nal_type = {1'b0, b[7:3]};
        end else if (i_cfg.codec == nlsc_pkg::CODEC_H265) begin
            nal_type = b[6:1];
        end else begin
            nal_type = {1'b0, b[4:0]};
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_seen  = r_seen;
        n_accum = r_accum;
        n_left  = r_left;
        n_held  = r_held;
        emit    = 1'b0;
        o_cmd   = '0;
        case (r_phase)
            nlsc_pkg::PH_LEN: begin
                n_accum = {r_accum[23:0], b};
                n_seen  = r_seen + 3'd1;
                if (n_seen >= eff_len) begin
                    if (n_accum == 32'd0) begin
                        // empty unit: four-byte start code alone
                        emit            = 1'b1;
                        o_cmd.has_start = 1'b1;
                    end else begin
                        n_left  = n_accum;
                        n_phase = nlsc_pkg::PH_FIRST;
                    end
                    n_accum = '0;
                    n_seen  = '0;
                end
            end
            nlsc_pkg::PH_FIRST: begin
                n_left = left_dec;
                if (i_cfg.codec == nlsc_pkg::CODEC_H266) begin
                    if (left_dec == 32'd0) begin
                        // single-byte unit has no type byte
                        emit            = 1'b1;
                        o_cmd.has_start = 1'b1;
                        o_cmd.ndata     = 2'd1;
                        o_cmd.d0        = b;
                        n_phase         = nlsc_pkg::PH_LEN;
                    end else begin
                        n_held  = b;
                        n_phase = nlsc_pkg::PH_HOLD;
                    end
                end else begin
                    emit            = 1'b1;
                    o_cmd.has_start = 1'b1;
                    o_cmd.start3    = i_cfg.start3_mask[nal_type];
                    o_cmd.ndata     = 2'd1;
                    o_cmd.d0        = b;
                    n_phase = (left_dec != 32'd0) ? nlsc_pkg::PH_BODY : nlsc_pkg::PH_LEN;
                end
            end
            nlsc_pkg::PH_HOLD: begin
                n_left          = left_dec;
                emit            = 1'b1;
                o_cmd.has_start = 1'b1;
                o_cmd.start3    = i_cfg.start3_mask[nal_type];
                o_cmd.ndata     = 2'd2;
                o_cmd.d0        = r_held;
                o_cmd.d1        = b;
                n_held          = '0;
                n_phase = (left_dec != 32'd0) ? nlsc_pkg::PH_BODY : nlsc_pkg::PH_LEN;
            end
            nlsc_pkg::PH_BODY: begin
                n_left      = left_dec;
                emit        = 1'b1;
                o_cmd.ndata = 2'd1;
                o_cmd.d0    = b;
                if (left_dec == 32'd0) begin
                    n_phase = nlsc_pkg::PH_LEN;
                end
            end
            default: begin
                n_phase = nlsc_pkg::PH_LEN;
            end
        endcase

        if (last) begin
            // packet end: a still untyped unit gets a start code, state clears
            if (n_phase == nlsc_pkg::PH_FIRST) begin
                emit            = 1'b1;
                o_cmd.has_start = 1'b1;
                o_cmd.start3    = 1'b0;
            end else if (n_phase == nlsc_pkg::PH_HOLD) begin
                emit            = 1'b1;
                o_cmd.has_start = 1'b1;
                o_cmd.start3    = 1'b0;
                o_cmd.ndata     = 2'd1;
                o_cmd.d0        = b;
            end
            n_phase = nlsc_pkg::PH_LEN;
            n_seen  = '0;
            n_accum = '0;
            n_left  = '0;
            n_held  = '0;
        end
        o_cmd.last = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= nlsc_pkg::PH_LEN;
            r_seen  <= '0;
            r_accum <= '0;
            r_left  <= '0;
            r_held  <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_seen  <= n_seen;
            r_accum <= n_accum;
            r_left  <= n_left;
            r_held  <= n_held;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/nlsc_fifo.sv =====
// nlsc_fifo: short command queue between front and back
// uses nlsc_pkg for the command and status types
`default_nettype none

module nlsc_fifo #(
    parameter int DEPTH = 4
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  nlsc_pkg::t_cmd       i_cmd,
    input  wire                  i_pop,
    output nlsc_pkg::t_cmd       o_head,
    output nlsc_pkg::t_q_status  o_status
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    nlsc_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0]  r_wr, n_wr;
    logic [PW-1:0]  r_rd, n_rd;
    logic [CW-1:0]  r_count, n_count;
    logic           do_push;
    logic           do_pop;

    assign o_status.full      = (r_count == CW'(DEPTH));
    assign o_status.not_empty = (r_count != '0);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && o_status.not_empty;
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/nlsc_back.sv =====
// nlsc_back: expands queued run commands into output bytes, one per cycle,
// unless stalled, through an output register; uses nlsc_pkg and nlsc_out_if
`default_nettype none

module nlsc_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  nlsc_pkg::t_cmd      i_head,
    input  nlsc_pkg::t_q_status i_q,
    output logic                o_pop,
    nlsc_out_if.source          o_out
);

    logic [2:0] r_pos, n_pos;
    logic       r_valid, n_valid;
    logic [7:0] r_byte;
    logic       r_lor;
    logic       r_pkt_end;

    logic [2:0] slen;
    logic [2:0] total;
    logic       load;
    logic       final_byte;
    logic [7:0] cur_byte;

    always_comb begin
        if (!i_head.has_start) begin
            slen = 3'd0;
        end else if (i_head.start3) begin
            slen = 3'd3;
        end else begin
            slen = 3'd4;
        end
    end

    assign total      = slen + {1'b0, i_head.ndata};
    assign final_byte = (r_pos == total - 3'd1);
    assign load       = i_q.not_empty && (!r_valid || o_out.ready);
    assign o_pop      = load && final_byte;

    always_comb begin
        if (r_pos < slen) begin
            // start code: zeros then a one
            cur_byte = (r_pos == slen - 3'd1) ? 8'h01 : 8'h00;
        end else if (r_pos == slen) begin
            cur_byte = i_head.d0;
        end else begin
            cur_byte = i_head.d1;
        end
    end

    always_comb begin
        n_pos   = r_pos;
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
            n_pos   = final_byte ? 3'd0 : r_pos + 3'd1;
        end else if (o_out.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte    <= cur_byte;
            r_lor     <= final_byte;
            r_pkt_end <= final_byte && i_head.last;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.out_byte    = r_byte;
    assign o_out.last_of_run = r_lor;
    assign o_out.packet_end  = r_pkt_end;

`ifndef ASSERT_OFF
    a_pkt_end_closes_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_pkt_end |-> r_lor)
        else $error("packet end on a byte that does not close its run");

    a_pos_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q.not_empty |-> (r_pos < total))
        else $error("run position beyond the run length");

    a_pop_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (load && final_byte))
        else $error("command popped without its final byte");

    a_pos_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_pos == 3'd0))
        else $error("run position not cleared after pop");
`endif

endmodule

`default_nettype wire

// ===== hdl/nal_length_prefix_to_start_code.sv =====
// nal_length_prefix_to_start_code: top level of the length-prefix to start-code framer
// holds the configuration registers; uses nlsc_pkg, nlsc_if, nlsc_front, nlsc_fifo, nlsc_back
//
//  channel   dir  handshake       payload
//  i_in      in   valid / ready   data_byte[7:0], last_in_packet
//  o_out     out  valid / ready   out_byte[7:0], last_of_run, packet_end
//  apb       in   psel / penable  paddr[4:0], pwdata[63:0], prdata[63:0]
//
// payload bytes pass at one item per cycle; a unit start yields up to six output bytes,
// one per cycle when not stalled, set by the single output byte register of the back end.
// items enter the command queue (QUEUE_DEPTH runs) and input stalls only when it is full.
// an item's output bytes pass through the command queue and then the output byte register.
// reset is synchronous, active low; no clearing pass, the block is ready right after.
`default_nettype none

module nal_length_prefix_to_start_code #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    nlsc_in_if.sink                          i_in,
    nlsc_out_if.source                       o_out,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire  [nlsc_pkg::ADDR_W-1:0]      paddr,
    input  wire  [nlsc_pkg::DATA_W-1:0]      pwdata,
    output logic [nlsc_pkg::DATA_W-1:0]      prdata,
    output logic                             pready
);

    logic [2:0]          r_len_bytes;
    logic [1:0]          r_codec;
    logic [63:0]         r_start3_mask;
    logic [1:0]          reg_idx;
    logic                wr_en;

    nlsc_pkg::t_cfg      cfg;
    nlsc_pkg::t_cmd      push_cmd;
    nlsc_pkg::t_cmd      head_cmd;
    nlsc_pkg::t_q_status q_stat;
    logic                push;
    logic                pop;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:3];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_bytes   <= nlsc_pkg::LEN_BYTES_RESET;
            r_codec       <= nlsc_pkg::CODEC_H264;
            r_start3_mask <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                nlsc_pkg::REG_LEN_BYTES: r_len_bytes   <= pwdata[2:0];
                nlsc_pkg::REG_CODEC:     r_codec       <= pwdata[1:0];
                nlsc_pkg::REG_START3:    r_start3_mask <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            nlsc_pkg::REG_LEN_BYTES: prdata = {61'd0, r_len_bytes};
            nlsc_pkg::REG_CODEC:     prdata = {62'd0, r_codec};
            nlsc_pkg::REG_START3:    prdata = r_start3_mask;
            default:                 prdata = '0;
        endcase
    end

    assign cfg.len_bytes   = r_len_bytes;
    assign cfg.codec       = r_codec;
    assign cfg.start3_mask = r_start3_mask;

    nlsc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (cfg),
        .i_q     (q_stat),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    nlsc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (push_cmd),
        .i_pop    (pop),
        .o_head   (head_cmd),
        .o_status (q_stat)
    );

    nlsc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head_cmd),
        .i_q     (q_stat),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

// ===== dv/nlsc_frame_checker.sv =====
// nlsc_frame_checker: watches the byte channels and the register port of the framer,
// predicts the start-code framed bytes and compares them in order; uses nlsc_pkg, nlsc_if
module nlsc_frame_checker (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    nlsc_in_if                           in_ch,
    nlsc_out_if                          out_ch,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [nlsc_pkg::ADDR_W-1:0]  paddr,
    input  wire  [nlsc_pkg::DATA_W-1:0]  pwdata,
    input  wire                          pready,
    output int                           o_fail_count,
    output int                           o_pending
);

    typedef struct packed {
        logic [7:0] data;
        logic       run_end;
        logic       pkt_end;
    } t_framed;

    t_framed     framed_q[$];

    logic [2:0]  cfg_len;
    logic [1:0]  cfg_codec;
    logic [63:0] cfg_mask;

    nlsc_pkg::t_phase nal_phase;
    logic [2:0]  len_seen;
    logic [31:0] len_acc;
    logic [31:0] bytes_left;
    logic [7:0]  held_byte;

    task automatic put_byte(input logic [7:0] b);
        t_framed e;
        e.data    = b;
        e.run_end = 1'b0;
        e.pkt_end = 1'b0;
        framed_q  = {framed_q, e};
    endtask

    // negative type: no type known, always the four-byte code
    task automatic put_start_code(input int nal_type);
        logic three;
        three = (nal_type >= 0) && cfg_mask[nal_type[5:0]];
        if (!three) put_byte(8'h00);
        put_byte(8'h00);
        put_byte(8'h00);
        put_byte(8'h01);
    endtask

    task automatic clear_unit();
        nal_phase  = nlsc_pkg::PH_LEN;
        len_seen   = '0;
        len_acc    = '0;
        bytes_left = '0;
        held_byte  = '0;
    endtask

    task automatic frame_byte(input logic [7:0] b, input logic last);
        int         first_new;
        logic [2:0] field_len;
        first_new = framed_q.size();
        field_len = (cfg_len < nlsc_pkg::LEN_BYTES_MIN) ? nlsc_pkg::LEN_BYTES_MIN :
                    (cfg_len > nlsc_pkg::LEN_BYTES_MAX) ? nlsc_pkg::LEN_BYTES_MAX : cfg_len;
        case (nal_phase)
            nlsc_pkg::PH_LEN: begin
                len_acc  = {len_acc[23:0], b};
                len_seen = len_seen + 3'd1;
                if (len_seen >= field_len) begin
                    if (len_acc == 0) begin
                        put_start_code(-1);
                    end else begin
                        bytes_left = len_acc;
                        nal_phase  = nlsc_pkg::PH_FIRST;
                    end
                    len_acc  = '0;
                    len_seen = '0;
                end
            end
            nlsc_pkg::PH_FIRST: begin
                bytes_left = bytes_left - 1;
                if (cfg_codec == nlsc_pkg::CODEC_H266) begin
                    if (bytes_left == 0) begin
                        put_start_code(-1);
                        put_byte(b);
                        nal_phase = nlsc_pkg::PH_LEN;
                    end else begin
                        held_byte = b;
                        nal_phase = nlsc_pkg::PH_HOLD;
                    end
                end else begin
                    put_start_code((cfg_codec == nlsc_pkg::CODEC_H265) ?
                                   int'(b[6:1]) : int'(b[4:0]));
                    put_byte(b);
                    nal_phase = (bytes_left != 0) ? nlsc_pkg::PH_BODY : nlsc_pkg::PH_LEN;
                end
            end
            nlsc_pkg::PH_HOLD: begin
                // a held byte finishes the h.266 way whatever the codec is now
                bytes_left = bytes_left - 1;
                put_start_code(int'(b[7:3]));
                put_byte(held_byte);
                put_byte(b);
                held_byte = '0;
                nal_phase = (bytes_left != 0) ? nlsc_pkg::PH_BODY : nlsc_pkg::PH_LEN;
            end
            default: begin
                put_byte(b);
                bytes_left = bytes_left - 1;
                if (bytes_left == 0) nal_phase = nlsc_pkg::PH_LEN;
            end
        endcase
        if (last) begin
            if (nal_phase == nlsc_pkg::PH_FIRST) begin
                put_start_code(-1);
            end else if (nal_phase == nlsc_pkg::PH_HOLD) begin
                put_start_code(-1);
                put_byte(held_byte);
            end
            clear_unit();
        end
        if (framed_q.size() > first_new) begin
            framed_q[framed_q.size()-1].run_end = 1'b1;
            framed_q[framed_q.size()-1].pkt_end = last;
        end
    endtask

    always @(posedge i_clk) begin
        t_framed want;
        if (!i_rst_n) begin
            cfg_len   = nlsc_pkg::LEN_BYTES_RESET;
            cfg_codec = nlsc_pkg::CODEC_H264;
            cfg_mask  = '0;
            clear_unit();
            framed_q.delete();
            o_fail_count = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:3])
                    nlsc_pkg::REG_LEN_BYTES: cfg_len   = pwdata[2:0];
                    nlsc_pkg::REG_CODEC:     cfg_codec = pwdata[1:0];
                    nlsc_pkg::REG_START3:    cfg_mask  = pwdata;
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready) frame_byte(in_ch.data_byte, in_ch.last_in_packet);
            if (out_ch.valid && out_ch.ready) begin
                if (framed_q.size() == 0) begin
                    $display("%0t: unexpected byte %02h last_of_run %0b packet_end %0b",
                             $time, out_ch.out_byte, out_ch.last_of_run, out_ch.packet_end);
                    o_fail_count++;
                end else begin
                    want = framed_q.pop_front();
                    if (want.data !== out_ch.out_byte || want.run_end !== out_ch.last_of_run ||
                        want.pkt_end !== out_ch.packet_end) begin
                        $display("%0t: expected %02h/%0b/%0b got %02h/%0b/%0b (byte/run/pkt)",
                                 $time, want.data, want.run_end, want.pkt_end,
                                 out_ch.out_byte, out_ch.last_of_run, out_ch.packet_end);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = framed_q.size();
    end

endmodule

// ===== dv/nal_length_prefix_to_start_code_tb.sv =====
// nal_length_prefix_to_start_code_tb: drives packets and register writes into the framer
// and reports the verdict; uses nlsc_pkg, nlsc_if, nlsc_frame_checker and the block
module nal_length_prefix_to_start_code_tb;

    localparam int STUCK_LIMIT = 2000;
    localparam int RAND_ITEMS  = 100;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [nlsc_pkg::ADDR_W-1:0] paddr;
    logic [nlsc_pkg::DATA_W-1:0] pwdata;
    logic [nlsc_pkg::DATA_W-1:0] prdata;
    logic                        pready;

    int   chk_fails;
    int   chk_pending;
    int   hold_left  = 0;
    int   stall_left = 0;
    bit   idle_en    = 1'b1;
    int   stuck      = 0;
    logic [7:0] pkt_q[$];

    nlsc_in_if  in_ch();
    nlsc_out_if out_ch();

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    nal_length_prefix_to_start_code DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    nlsc_frame_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_fail_count (chk_fails),
        .o_pending    (chk_pending)
    );

    // output side: long hold-off when hold_left is set, else random stall bursts
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else if (idle_en && $urandom_range(0, 9) == 0) begin
                out_ch.ready <= 1'b0;
                stall_left = $urandom_range(1, 16) - 1;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (psel && penable)) begin
            stuck <= 0;
        end else begin
            stuck <= stuck + 1;
        end
        if (stuck >= STUCK_LIMIT) begin
            $display("FAIL nal_length_prefix_to_start_code");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(input logic [2:0] len, input logic [1:0] codec,
                              input logic [63:0] mask);
        write_reg(nlsc_pkg::REG_LEN_BYTES, {61'd0, len});
        write_reg(nlsc_pkg::REG_CODEC, {62'd0, codec});
        write_reg(nlsc_pkg::REG_START3, mask);
    endtask

    // sends the first count bytes of pkt_q, marking the end of packet if asked
    task automatic send_packet(input int count, input logic mark_last);
        for (int i = 0; i < count; i++) begin
            @(negedge i_clk);
            if (idle_en && $urandom_range(0, 4) == 0) begin
                in_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge i_clk);
            end
            in_ch.valid          <= 1'b1;
            in_ch.data_byte      <= pkt_q[i];
            in_ch.last_in_packet <= mark_last && (i == count - 1);
            do @(posedge i_clk); while (!in_ch.ready);
        end
    endtask

    // items that make no output may still be inside, so linger a bit
    task automatic drain();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (chk_pending != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    // mostly well-formed units; some zero length, huge noise lengths, a cut or extra bytes
    task automatic build_packet(input int field_len);
        int          nunits;
        int          kind;
        int          nbody;
        logic [31:0] lv;
        pkt_q.delete();
        nunits = $urandom_range(1, 3);
        for (int u = 0; u < nunits; u++) begin
            kind = $urandom_range(0, 15);
            if (kind == 0)      lv = $urandom();
            else if (kind == 1) lv = 0;
            else if (kind < 4)  lv = $urandom_range(1, 2);
            else if (kind == 4) lv = $urandom_range(8, 24);
            else                lv = $urandom_range(3, 6);
            if (field_len < 4) lv = lv & ((32'd1 << (8 * field_len)) - 1);
            for (int k = field_len - 1; k >= 0; k--) pkt_q = {pkt_q, lv[8*k +: 8]};
            nbody = (lv > 24) ? $urandom_range(0, 4) : int'(lv);
            for (int k = 0; k < nbody; k++) pkt_q = {pkt_q, 8'($urandom_range(0, 255))};
        end
        case ($urandom_range(0, 7))
            0: if (pkt_q.size() > 2) repeat ($urandom_range(1, 2)) void'(pkt_q.pop_back());
            1: repeat ($urandom_range(1, field_len - 1))
                   pkt_q = {pkt_q, 8'($urandom_range(0, 255))};
            default: ;
        endcase
    endtask

    initial begin
        logic [2:0]  len_reg;
        logic [1:0]  codec_reg;
        logic [63:0] mask_reg;
        int          field_len;
        int          rand_items;
        int          phase_items;
        int          phase_n;
        int          cut;
        i_rst_n              = 1'b0;
        in_ch.valid          = 1'b0;
        in_ch.data_byte      = '0;
        in_ch.last_in_packet = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: zero-length unit, then a one-byte h.264 unit
        pkt_q = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'hFF};
        send_packet(pkt_q.size(), 1'b1);
        drain();

        // h.266: one-byte unit with no type, held byte then type 31, held byte at the end
        set_config(3'd2, nlsc_pkg::CODEC_H266, '1);
        pkt_q = '{8'h00, 8'h01, 8'h00, 8'h00, 8'h03, 8'hAA, 8'hF8, 8'h55,
                  8'h00, 8'h02, 8'h7F};
        send_packet(pkt_q.size(), 1'b1);
        drain();

        // h.265: truncated unit, partial length field, end right after the field
        set_config(3'd3, nlsc_pkg::CODEC_H265, '0);
        pkt_q = '{8'h00, 8'h00, 8'h05, 8'h7E, 8'h01};
        send_packet(pkt_q.size(), 1'b1);
        pkt_q = '{8'h00, 8'h00};
        send_packet(pkt_q.size(), 1'b1);
        pkt_q = '{8'h00, 8'h00, 8'h02};
        send_packet(pkt_q.size(), 1'b1);

        rand_items = 0;
        phase_n    = 0;
        while (rand_items < RAND_ITEMS) begin
            drain();
            case (phase_n)
                0: begin
                    len_reg   = 3'd2;
                    codec_reg = nlsc_pkg::CODEC_H264;
                    mask_reg  = '0;
                end
                1: begin
                    len_reg   = 3'd4;
                    codec_reg = nlsc_pkg::CODEC_H266;
                    mask_reg  = '1;
                end
                2: begin
                    len_reg   = 3'd3;
                    codec_reg = nlsc_pkg::CODEC_H265;
                    mask_reg  = {$urandom(), $urandom()};
                end
                default: begin
                    len_reg   = 3'($urandom_range(0, 7));
                    codec_reg = 2'($urandom_range(0, 3));
                    case ($urandom_range(0, 3))
                        0:       mask_reg = '0;
                        1:       mask_reg = '1;
                        default: mask_reg = {$urandom(), $urandom()};
                    endcase
                end
            endcase
            set_config(len_reg, codec_reg, mask_reg);
            field_len = (len_reg < nlsc_pkg::LEN_BYTES_MIN) ? nlsc_pkg::LEN_BYTES_MIN :
                        (len_reg > nlsc_pkg::LEN_BYTES_MAX) ? nlsc_pkg::LEN_BYTES_MAX :
                        len_reg;
            // receiver holds off while the sender keeps going, so the input backs up
            if (phase_n == 1) hold_left = 300;
            phase_items = 0;
            while (phase_items < 25 && rand_items < RAND_ITEMS) begin
                if (rand_items > RAND_ITEMS - 25) idle_en = 1'b0;
                build_packet(field_len);
                send_packet(pkt_q.size(), 1'b1);
                phase_items += pkt_q.size();
                rand_items  += pkt_q.size();
            end
            // sometimes leave a unit open across the next register change
            if ($urandom_range(0, 2) == 0) begin
                build_packet(field_len);
                cut = $urandom_range(1, pkt_q.size());
                send_packet(cut, 1'b0);
                rand_items += cut;
            end
            phase_n++;
        end

        drain();
        repeat (16) @(negedge i_clk);
        if (chk_fails == 0 && chk_pending == 0) begin
            $display("PASS nal_length_prefix_to_start_code");
        end else begin
            $display("FAIL nal_length_prefix_to_start_code");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/nlsc_pkg.sv
hdl/nlsc_if.sv
hdl/nlsc_front.sv
hdl/nlsc_fifo.sv
hdl/nlsc_back.sv
hdl/nal_length_prefix_to_start_code.sv
dv/nlsc_frame_checker.sv
dv/nal_length_prefix_to_start_code_tb.sv
